// ----- hdl/debug_mailbox_serial_endpoint_macros.svh -----
// assertion macros for the debug mailbox serial endpoint
// expects clk and rst_n to be visible where a macro is used
`ifndef DEBUG_MAILBOX_SERIAL_ENDPOINT_MACROS_SVH
`define DEBUG_MAILBOX_SERIAL_ENDPOINT_MACROS_SVH

// same-cycle implication
`define DMSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dmse_pkg.sv -----
// shared types, constants and helpers of the debug mailbox serial endpoint
// no dependencies
package dmse_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int HELD_W     = 6;
    localparam int WAIT_W     = 16;
    localparam int FRAME_IN   = 3;
    localparam int CHUNK_MAX  = 7;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEPTH_C = cnt_t'(RING_DEPTH);

    localparam logic [7:0] STAT_PEND     = 8'h80;
    localparam logic [7:0] STAT_TMO      = 8'h40;
    localparam logic [5:0] STAT_CNT_MASK = 6'h3f;
    localparam logic [5:0] ST_BIAS       = 6'd4;
    localparam logic [7:0] ST_POLL_ACK   = STAT_PEND | 8'(ST_BIAS);
    localparam logic [WAIT_W-1:0] WAIT_LIMIT_RST = '1;

    typedef enum logic [1:0] {
        ACT_SERVICE = 2'd0,
        ACT_BEGIN   = 2'd1,
        ACT_END     = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        SEND_NONE    = 3'd0,
        SEND_SENT    = 3'd1,
        SEND_WAIT    = 3'd2,
        SEND_TIMEOUT = 3'd3,
        SEND_REFUSED = 3'd4
    } send_status_t;

    typedef struct packed {
        logic              word0_write;
        logic [31:0]       word0_value;
        logic              word1_write;
        logic [31:0]       word1_value;
        logic              byte_valid;
        logic [7:0]        rx_byte;
        logic [HELD_W-1:0] held_count;
        logic [2:0]        send_status;
    } res_t;

    function automatic ptr_t ring_next(input ptr_t p);
        return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

endpackage

// ----- hdl/dmse_ifs.sv -----
// request channels of the debug mailbox serial endpoint: item, result, config
// depends on dmse_pkg
interface dmse_item_if import dmse_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] mailbox_word;
    logic        pop_req;
    logic [2:0]  send_count;
    logic [55:0] send_bytes;

    modport source (output valid, action, mailbox_word, pop_req, send_count, send_bytes,
                    input ready);
    modport sink   (input valid, action, mailbox_word, pop_req, send_count, send_bytes,
                    output ready);
endinterface

interface dmse_result_if import dmse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              word0_write;
    logic [31:0]       word0_value;
    logic              word1_write;
    logic [31:0]       word1_value;
    logic              byte_valid;
    logic [7:0]        rx_byte;
    logic [HELD_W-1:0] held_count;
    logic [2:0]        send_status;

    modport source (output valid, word0_write, word0_value, word1_write, word1_value,
                    byte_valid, rx_byte, held_count, send_status, input ready);
    modport sink   (input valid, word0_write, word0_value, word1_write, word1_value,
                    byte_valid, rx_byte, held_count, send_status, output ready);
endinterface

interface dmse_cfg_if import dmse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] wait_limit;

    modport source (output valid, wait_limit, input ready);
    modport sink   (input valid, wait_limit, output ready);
endinterface

// ----- hdl/debug_mailbox_serial_endpoint.sv -----
// debug mailbox serial endpoint top level; uses dmse_pkg, dmse_ifs, dmse_ctrl,
// dmse_ring_ram and dmse_out_reg
// a result is registered in stage 1 when its item is accepted, then in the output register
// throughput: 1 item per cycle while the result path takes results; an item that stores
// n host bytes (at most 3) holds off the input until the single ram write port stores them
// reset: pointers, session and wait counter cleared, wait_limit 65535; ring ram not cleared
`include "debug_mailbox_serial_endpoint_macros.svh"

module debug_mailbox_serial_endpoint import dmse_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    dmse_item_if.sink     item,
    dmse_cfg_if.sink      cfg,
    dmse_result_if.source result
);

    logic       ram_we;
    ptr_t       ram_waddr;
    logic [7:0] ram_wdata;
    logic       ram_re;
    ptr_t       ram_raddr;
    logic [7:0] ram_rdata;
    logic       s1_valid;
    res_t       s1_res;
    logic       s1_take;

    dmse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .s1_valid  (s1_valid),
        .s1_res    (s1_res),
        .s1_take   (s1_take)
    );

    dmse_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (8)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dmse_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_res   (s1_res),
        .s1_take  (s1_take),
        .result   (result)
    );

    // ring writes outside an accepted request only happen while the input is held off
    `DMSE_ASSERT_IMPL(a_drain_blocks_input, ram_we && !(item.valid && item.ready), !item.ready, "ring write drain while input ready")
    `DMSE_ASSERT_NEXT(a_accept_fills_stage, item.valid && item.ready, s1_valid, "accepted request missing from result stage")
    `DMSE_ASSERT_IMPL(a_no_byte_reads_zero, result.valid && !result.byte_valid, result.rx_byte == 8'd0, "rx_byte set without byte_valid")
    `DMSE_ASSERT_IMPL(a_refused_no_write, result.valid && (result.send_status == SEND_REFUSED), !result.word0_write && !result.word1_write, "refused send wrote the mailbox")

endmodule

// ----- hdl/dmse_ring_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module dmse_ring_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/dmse_ctrl.sv -----
// session, pointer and send logic; sequences ring writes and issues the ring read
// depends on dmse_pkg and dmse_ifs
module dmse_ctrl import dmse_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    dmse_item_if.sink     item,
    dmse_cfg_if.sink      cfg,
    output logic          ram_we,
    output ptr_t          ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic          ram_re,
    output ptr_t          ram_raddr,
    input  logic [7:0]    ram_rdata,
    output logic          s1_valid,
    output res_t          s1_res,
    input  logic          s1_take
);

    ptr_t              rp_reg, rp_next;
    ptr_t              wp_reg, wp_next;
    logic              session_reg, session_next;
    logic [WAIT_W-1:0] wait_seen_reg, wait_seen_next;
    logic [WAIT_W-1:0] wait_limit_reg;
    logic [1:0]        wr_left_reg;
    ptr_t              wr_addr_reg;
    logic [7:0]        wr_buf_reg [2];
    logic              s1_valid_reg;
    res_t              s1_res_reg;
    logic              s1_use_ram_reg;

    logic              accept;
    logic              is_service;
    logic              pending;
    cnt_t              held;
    cnt_t              held_poll;
    cnt_t              held_fin;
    logic [5:0]        host_cnt;
    logic [5:0]        excess;
    logic [1:0]        host_n;
    logic [1:0]        n;
    logic              poll_ok;
    ptr_t              wp1, wp2, wp3, wp_poll;
    logic              rd_hit;
    logic              pop_now;
    logic              use_ram;
    logic [WAIT_W-1:0] lim;
    logic [WAIT_W:0]   seen_inc;
    logic [7:0]        p [CHUNK_MAX];
    res_t              res;

    assign accept     = item.valid && item.ready;
    assign item.ready = (wr_left_reg == 2'd0) && (!s1_valid_reg || s1_take);
    assign cfg.ready  = 1'b1;

    // ring occupancy and host frame size
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            held = cnt_t'(wp_reg - rp_reg);
        end
        else
        begin
            held = DEPTH_C + cnt_t'(wp_reg) - cnt_t'(rp_reg);
        end

        host_cnt = item.mailbox_word[5:0] & STAT_CNT_MASK;
        excess   = host_cnt - ST_BIAS;
        if (host_cnt > ST_BIAS)
        begin
            host_n = (excess > 6'(FRAME_IN)) ? 2'(FRAME_IN) : excess[1:0];
        end
        else
        begin
            host_n = 2'd0;
        end
    end

    assign is_service = (item.action == ACT_SERVICE);
    assign pending    = (item.mailbox_word[7:0] & STAT_PEND) != 8'd0;
    assign poll_ok    = session_reg && is_service && !pending
                        && (held + cnt_t'(FRAME_IN) < DEPTH_C);
    assign n          = poll_ok ? host_n : 2'd0;

    assign wp1 = ring_next(wp_reg);
    assign wp2 = ring_next(wp1);
    assign wp3 = ring_next(wp2);

    always_comb
    begin
        case (n)
            2'd1:    wp_poll = wp1;
            2'd2:    wp_poll = wp2;
            2'd3:    wp_poll = wp3;
            default: wp_poll = wp_reg;
        endcase
    end

    assign held_poll = held + cnt_t'(n);
    assign rd_hit    = session_reg && is_service && (held_poll != '0);
    assign pop_now   = rd_hit && item.pop_req;
    assign held_fin  = held_poll - cnt_t'(pop_now);
    // an empty ring reads back the first byte this item stores
    assign use_ram   = rd_hit && (held != '0);

    assign lim      = (wait_limit_reg == '0) ? WAIT_W'(1) : wait_limit_reg;
    assign seen_inc = {1'b0, wait_seen_reg} + (WAIT_W+1)'(1);

    always_comb
    begin
        for (int k = 0; k < CHUNK_MAX; k++)
        begin
            p[k] = (k < int'(item.send_count)) ? item.send_bytes[8*k +: 8] : 8'd0;
        end
    end

    // outcome of the item at the input and the state it leaves
    always_comb
    begin
        res            = '0;
        res.held_count = HELD_W'(held);
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        session_next   = session_reg;
        wait_seen_next = wait_seen_reg;

        unique case (item.action)
            ACT_BEGIN:
            begin
                res.word0_write = 1'b1;
                res.held_count  = '0;
                rp_next         = '0;
                wp_next         = '0;
                session_next    = 1'b1;
                wait_seen_next  = '0;
            end
            ACT_END:
            begin
                session_next   = 1'b0;
                wait_seen_next = '0;
            end
            ACT_SERVICE:
            begin
                if (!session_reg)
                begin
                    if (item.send_count != 3'd0)
                    begin
                        res.send_status = SEND_REFUSED;
                    end
                end
                else
                begin
                    if (poll_ok)
                    begin
                        res.word0_write = 1'b1;
                        res.word0_value = {24'd0, ST_POLL_ACK};
                    end

                    if (item.send_count == 3'd0)
                    begin
                        wait_seen_next = '0;
                    end
                    else if ((item.mailbox_word[7:0] & (STAT_PEND | STAT_TMO))
                             == (STAT_PEND | STAT_TMO))
                    begin
                        res.send_status = SEND_REFUSED;
                        wait_seen_next  = '0;
                    end
                    else if (pending)
                    begin
                        if (seen_inc >= {1'b0, lim})
                        begin
                            res.word0_write = 1'b1;
                            res.word0_value = item.mailbox_word | {24'd0, STAT_TMO};
                            res.send_status = SEND_TIMEOUT;
                            wait_seen_next  = '0;
                        end
                        else
                        begin
                            res.send_status = SEND_WAIT;
                            wait_seen_next  = seen_inc[WAIT_W-1:0];
                        end
                    end
                    else
                    begin
                        res.word1_write = 1'b1;
                        res.word1_value = {p[6], p[5], p[4], p[3]};
                        res.word0_write = 1'b1;
                        res.word0_value = {p[2], p[1], p[0],
                                           STAT_PEND | (8'(item.send_count) + 8'(ST_BIAS))};
                        res.send_status = SEND_SENT;
                        wait_seen_next  = '0;
                    end

                    res.byte_valid = rd_hit;
                    res.rx_byte    = (rd_hit && !use_ram) ? item.mailbox_word[15:8] : 8'd0;
                    res.held_count = HELD_W'(held_fin);
                    wp_next        = wp_poll;
                    rp_next        = pop_now ? ring_next(rp_reg) : rp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ring write port: first byte at accept, the rest drain one per cycle
    assign ram_we    = (wr_left_reg != 2'd0) || (accept && (n != 2'd0));
    assign ram_waddr = (wr_left_reg != 2'd0) ? wr_addr_reg : wp_reg;
    assign ram_wdata = (wr_left_reg != 2'd0) ? wr_buf_reg[0] : item.mailbox_word[15:8];
    assign ram_re    = accept;
    assign ram_raddr = rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg         <= '0;
            wp_reg         <= '0;
            session_reg    <= 1'b0;
            wait_seen_reg  <= '0;
            wait_limit_reg <= WAIT_LIMIT_RST;
            wr_left_reg    <= 2'd0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                wait_limit_reg <= cfg.wait_limit;
            end

            if (accept)
            begin
                rp_reg        <= rp_next;
                wp_reg        <= wp_next;
                session_reg   <= session_next;
                wait_seen_reg <= wait_seen_next;
            end

            if (wr_left_reg != 2'd0)
            begin
                wr_left_reg <= wr_left_reg - 2'd1;
            end
            else if (accept && (n != 2'd0))
            begin
                wr_left_reg <= n - 2'd1;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_left_reg != 2'd0)
        begin
            wr_addr_reg   <= ring_next(wr_addr_reg);
            wr_buf_reg[0] <= wr_buf_reg[1];
        end
        else if (accept)
        begin
            wr_addr_reg   <= wp1;
            wr_buf_reg[0] <= item.mailbox_word[23:16];
            wr_buf_reg[1] <= item.mailbox_word[31:24];
        end

        if (accept)
        begin
            s1_res_reg     <= res;
            s1_use_ram_reg <= use_ram;
        end
    end

    always_comb
    begin
        s1_res         = s1_res_reg;
        s1_res.rx_byte = s1_use_ram_reg ? ram_rdata : s1_res_reg.rx_byte;
    end

    assign s1_valid = s1_valid_reg;

endmodule

// ----- hdl/dmse_out_reg.sv -----
// output register of the result channel
// depends on dmse_pkg and dmse_ifs
module dmse_out_reg import dmse_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s1_valid,
    input  res_t          s1_res,
    output logic          s1_take,
    dmse_result_if.source result
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign s1_take = s1_valid && (!valid_reg || result.ready);

    always_comb
    begin
        if (s1_take)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            res_reg <= s1_res;
        end
    end

    assign result.valid       = valid_reg;
    assign result.word0_write = res_reg.word0_write;
    assign result.word0_value = res_reg.word0_value;
    assign result.word1_write = res_reg.word1_write;
    assign result.word1_value = res_reg.word1_value;
    assign result.byte_valid  = res_reg.byte_valid;
    assign result.rx_byte     = res_reg.rx_byte;
    assign result.held_count  = res_reg.held_count;
    assign result.send_status = res_reg.send_status;

endmodule
